@@ design/ste_pkg.sv @@
package ste_pkg;

   // grid size defaults
   localparam int GRID_COLS_DEF = 64;
   localparam int GRID_ROWS_DEF = 64;

   // stored height width; the word also carries a pending bit
   localparam int HEIGHT_W = 8;
   localparam int THR_W    = 4;
   localparam int COORD_W  = 6;
   localparam int SIZE_W   = 32;
   localparam int AVAL_W   = 14;

   localparam logic [THR_W-1:0] THR_MIN   = 4'd4;
   localparam logic [THR_W-1:0] THR_RESET = 4'd4;

   // neighbor directions: up, down, left, right
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DROP_RD,
      ST_DROP_WR,
      ST_POP,
      ST_FETCH,
      ST_CELL,
      ST_NBR_RD,
      ST_NBR_WR,
      ST_DONE
   } state_type;

endpackage

@@ design/ste_ram.sv @@
module ste_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sandpile_toppling_engine.sv @@
// Sandpile toppling engine. Each req word drops one grain at (drop_row, drop_col) if that
// cell lies in the grid; one rsp word follows with the toppling count of the resulting
// avalanche and the running counters. Cell heights live in a single-port-write grid RAM and
// unstable cells wait on a stack RAM, so the block works one drop at a time. After reset the
// grid RAM is cleared, one cell a cycle, over all GRID_COLS*GRID_ROWS cells, during which
// req_ready stays low. Threshold values below 4 act as 4.
module sandpile_toppling_engine
   import ste_pkg::*;
#(
   parameter int GRID_COLS = GRID_COLS_DEF,
   parameter int GRID_ROWS = GRID_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [THR_W-1:0]   csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_drop_col,
   input  logic [COORD_W-1:0] req_drop_row,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_drop_accepted,
   output logic [SIZE_W-1:0]  rsp_avalanche_size,
   output logic [AVAL_W-1:0]  rsp_avalanche_total,
   output logic [SIZE_W-1:0]  rsp_grains_dropped
);

   localparam int CELLS  = GRID_COLS * GRID_ROWS;
   localparam int CW     = $clog2(GRID_COLS);
   localparam int RW     = $clog2(GRID_ROWS);
   localparam int AW     = $clog2(CELLS);
   localparam int WORD_W = HEIGHT_W + 1;
   localparam int PT_W   = RW + CW;

   state_type state_ff, state_in;

   logic [THR_W-1:0]    thr_ff;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [AW:0]         sp_ff, sp_in;
   logic [1:0]          dir_ff, dir_in;
   logic [HEIGHT_W-1:0] k_ff, k_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [SIZE_W-1:0]   drops_ff, drops_in;
   logic [AVAL_W-1:0]   aval_ff, aval_in;
   logic                acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                g_we;
   logic [AW-1:0]       g_waddr, g_raddr;
   logic [WORD_W-1:0]   g_wdata, g_rdata;
   logic                s_we;
   logic [AW-1:0]       s_waddr, s_raddr;
   logic [PT_W-1:0]     s_wdata, s_rdata;

   logic [HEIGHT_W-1:0] thr_eff;
   logic [HEIGHT_W-1:0] cur_h, nbr_h, k_new;
   logic                cur_pend, push;
   logic                in_grid, nbr_ok;
   logic [RW-1:0]       nbr_row, pop_row;
   logic [CW-1:0]       nbr_col, pop_col;
   logic [AW-1:0]       cur_addr, nbr_addr, drop_addr;
   logic [SIZE_W:0]     size_sum;

   ste_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_grid (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr (g_waddr),
      .wr_data (g_wdata),
      .rd_addr (g_raddr),
      .rd_data (g_rdata)
   );

   ste_ram #(.WIDTH(PT_W), .DEPTH(CELLS)) u_stack (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   // effective threshold and cell word fields
   assign thr_eff  = (thr_ff < THR_MIN) ? HEIGHT_W'(THR_MIN) : HEIGHT_W'(thr_ff);
   assign cur_h    = g_rdata[HEIGHT_W-1:0];
   assign cur_pend = g_rdata[HEIGHT_W];
   assign k_new    = ((cur_h - thr_eff) >> 2) + HEIGHT_W'(1);
   assign size_sum = {1'b0, size_ff} + (SIZE_W + 1)'(k_ff);

   assign in_grid = ({3'b0, req_drop_col} < 9'(GRID_COLS)) &&
                    ({3'b0, req_drop_row} < 9'(GRID_ROWS));
   assign drop_addr = AW'(AW'(req_drop_row) * AW'(GRID_ROWS > 0 ? GRID_COLS : 1)) +
                      AW'(req_drop_col);
   assign cur_addr  = AW'(AW'(row_ff) * AW'(GRID_COLS)) + AW'(col_ff);
   assign pop_row   = s_rdata[PT_W-1:CW];
   assign pop_col   = s_rdata[CW-1:0];

   // neighbor of the cell being toppled
   always_comb begin
      nbr_row = row_ff;
      nbr_col = col_ff;
      nbr_ok  = 1'b0;
      unique case (dir_ff)
         DIR_UP: begin
            nbr_row = row_ff - RW'(1);
            nbr_ok  = (row_ff != '0);
         end
         DIR_DOWN: begin
            nbr_row = row_ff + RW'(1);
            nbr_ok  = (row_ff != RW'(GRID_ROWS - 1));
         end
         DIR_LEFT: begin
            nbr_col = col_ff - CW'(1);
            nbr_ok  = (col_ff != '0);
         end
         DIR_RIGHT: begin
            nbr_col = col_ff + CW'(1);
            nbr_ok  = (col_ff != CW'(GRID_COLS - 1));
         end
      endcase
   end
   assign nbr_addr = AW'(AW'(nbr_row) * AW'(GRID_COLS)) + AW'(nbr_col);

   // added height and push decision for drop and neighbor updates
   always_comb begin
      nbr_h = cur_h + ((state_ff == ST_DROP_WR) ? HEIGHT_W'(1) : k_ff);
      push  = (nbr_h >= thr_eff) && !cur_pend;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (clr_ff == AW'(CELLS - 1)) state_in = ST_IDLE;
         ST_IDLE:    if (req_valid && req_ready) state_in = in_grid ? ST_DROP_RD : ST_DONE;
         ST_DROP_RD: state_in = ST_DROP_WR;
         ST_DROP_WR: state_in = push ? ST_POP : ST_DONE;
         ST_POP:     state_in = ST_FETCH;
         ST_FETCH:   state_in = ST_CELL;
         ST_CELL: begin
            if (cur_h >= thr_eff) state_in = ST_NBR_RD;
            else if (sp_ff == '0) state_in = ST_DONE;
            else state_in = ST_POP;
         end
         ST_NBR_RD: begin
            if (nbr_ok) state_in = ST_NBR_WR;
            else if (dir_ff == DIR_RIGHT) state_in = (sp_ff == '0) ? ST_DONE : ST_POP;
         end
         ST_NBR_WR: begin
            if (dir_ff != DIR_RIGHT) state_in = ST_NBR_RD;
            else if (sp_ff == '0 && !push) state_in = ST_DONE;
            else state_in = ST_POP;
         end
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   // datapath and RAM controls
   always_comb begin
      clr_in       = clr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      sp_in        = sp_ff;
      dir_in       = dir_ff;
      k_in         = k_ff;
      size_in      = size_ff;
      drops_in     = drops_ff;
      aval_in      = aval_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      g_we         = 1'b0;
      g_waddr      = cur_addr;
      g_wdata      = '0;
      g_raddr      = cur_addr;
      s_we         = 1'b0;
      s_waddr      = sp_ff[AW-1:0];
      s_wdata      = {row_ff, col_ff};
      s_raddr      = sp_ff[AW-1:0] - AW'(1);
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            g_we    = 1'b1;
            g_waddr = clr_ff;
            clr_in  = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff;
            g_raddr   = drop_addr;
            if (req_valid && !rsp_valid_ff) begin
               row_in  = RW'(req_drop_row);
               col_in  = CW'(req_drop_col);
               acc_in  = in_grid;
               size_in = '0;
               sp_in   = '0;
            end
         end
         ST_DROP_RD: ;
         ST_DROP_WR: begin
            g_we    = 1'b1;
            g_wdata = {push, nbr_h};
            if (drops_ff != '1) drops_in = drops_ff + SIZE_W'(1);
            if (push) begin
               s_we  = 1'b1;
               sp_in = sp_ff + (AW + 1)'(1);
            end
         end
         ST_POP: sp_in = sp_ff - (AW + 1)'(1);
         ST_FETCH: begin
            row_in  = pop_row;
            col_in  = pop_col;
            g_raddr = AW'(AW'(pop_row) * AW'(GRID_COLS)) + AW'(pop_col);
         end
         ST_CELL: begin
            g_we   = 1'b1;
            dir_in = DIR_UP;
            if (cur_h >= thr_eff) begin
               g_wdata = {1'b0, cur_h - (k_new << 2)};
               k_in    = k_new;
            end else begin
               g_wdata = {1'b0, cur_h};
            end
         end
         ST_NBR_RD: begin
            g_raddr = nbr_addr;
            if (!nbr_ok) dir_in = dir_ff + 2'd1;
            if (dir_ff == DIR_UP) begin
               size_in = size_sum[SIZE_W] ? '1 : size_sum[SIZE_W-1:0];
            end
         end
         ST_NBR_WR: begin
            g_we    = 1'b1;
            g_waddr = nbr_addr;
            g_wdata = {cur_pend | push, nbr_h};
            dir_in  = dir_ff + 2'd1;
            s_wdata = {nbr_row, nbr_col};
            if (push) begin
               s_we  = 1'b1;
               sp_in = sp_ff + (AW + 1)'(1);
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (size_ff != '0 && aval_ff != '1) aval_in = aval_ff + AVAL_W'(1);
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         drops_ff     <= '0;
         aval_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         drops_ff     <= drops_in;
         aval_ff      <= aval_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) thr_ff <= csr_write_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      dir_ff  <= dir_in;
      k_ff    <= k_in;
      size_ff <= size_in;
      acc_ff  <= acc_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drop_accepted   = acc_ff;
   assign rsp_avalanche_size  = size_ff;
   assign rsp_avalanche_total = aval_ff;
   assign rsp_grains_dropped  = drops_ff;

endmodule

@@ design/ste_checker.sv @@
module ste_checker
   import ste_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_drop_accepted,
   input logic [SIZE_W-1:0]  rsp_avalanche_size,
   input logic [AVAL_W-1:0]  rsp_avalanche_total,
   input logic [SIZE_W-1:0]  rsp_grains_dropped
);

   // a pending result word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_avalanche_size) &&
      $stable(rsp_avalanche_total))
      else $error("rsp word dropped or changed while stalled");

   // one drop in flight: no new word while a result waits
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req taken while rsp pending");

   // a rejected drop never topples anything
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drop_accepted |-> rsp_avalanche_size == '0)
      else $error("off-grid drop reported topplings");

   // drop counter only moves up
   a_drops_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> rsp_grains_dropped >= $past(rsp_grains_dropped))
      else $error("grain count went down");

endmodule

bind sandpile_toppling_engine ste_checker u_ste_checker (.*);
